// File: hw/rtl/ppt_pkg.sv
// Shared types, constants and codes for the process priority table.
package ppt_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int ENTRY_W     = 64;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;
  localparam logic [1:0] OP_SORT   = 2'd2;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_FULL  = 2'd1;
  localparam logic [1:0] STAT_EMPTY = 2'd2;

  typedef struct packed {
    logic        [1:0]  opcode;
    logic        [15:0] name_tag;
    logic signed [15:0] priority_req;
    logic        [31:0] size_value;
  } in_item_t;

  typedef struct packed {
    logic        [1:0]  status;
    logic        [15:0] removed_tag;
    logic signed [15:0] removed_priority;
    logic        [31:0] removed_size;
    logic        [6:0]  entry_count;
  } out_item_t;

  typedef struct packed {
    logic        [15:0] tag;
    logic signed [15:0] prio;
    logic        [31:0] size;
  } entry_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_REM_HEAD,
    S_REM_SHIFT,
    S_SORT_I,
    S_SORT_J,
    S_SORT_WB
  } fsm_t;

  // Sort order: ascending priority, then ascending size.
  function automatic logic entry_greater(entry_t a, entry_t b);
    logic gt;
    if (a.prio != b.prio) begin
      gt = (a.prio > b.prio);
    end else begin
      gt = (a.size > b.size);
    end
    return gt;
  endfunction

endpackage

// File: hw/rtl/process_priority_table_unit.sv
// Process priority table: control sequencer around the entry RAM.
// Insert, no-op, full, empty and short sort (under two entries) cases: done pulses in the cycle after start is taken.
// Remove: the head entry is read out, then each later entry moves down one slot (one RAM move per cycle).
// Sort of n entries: one compare-swap per cycle on the RAM port during each inner pass.
// busy is high only while a remove or sort is under way and is low in the done cycle; the result must be taken then.
// Synchronous reset empties the table; RAM contents are not cleared.
module process_priority_table_unit
  import ppt_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  in_item_t  cmd,
  output logic      busy,
  output logic      done,
  output out_item_t result
);

  fsm_t             state, state_next;
  logic [CNT_W-1:0] count, count_next;
  logic [CNT_W-1:0] idx_i, idx_i_next;
  logic [CNT_W-1:0] idx_j, idx_j_next;
  entry_t           cur, cur_next;
  out_item_t        res, res_next;
  logic             done_next;

  logic             we;
  logic [IDX_W-1:0] waddr;
  entry_t           wdata;
  logic [IDX_W-1:0] raddr;
  logic [ENTRY_W-1:0] rdata;
  entry_t           rd_entry;

  logic [CNT_W-1:0] j_inc;
  logic [CNT_W-1:0] i_inc;
  logic [CNT_W-1:0] i_inc2;

  ppt_ram #(
    .DEPTH(TABLE_DEPTH),
    .WIDTH(ENTRY_W)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  assign rd_entry = rdata;
  assign j_inc    = idx_j + 1'b1;
  assign i_inc    = idx_i + 1'b1;
  assign i_inc2   = idx_i + 2'd2;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      done  <= done_next;
    end
    idx_i <= idx_i_next;
    idx_j <= idx_j_next;
    cur   <= cur_next;
    res   <= res_next;
  end

  always_comb begin
    state_next = state;
    count_next = count;
    idx_i_next = idx_i;
    idx_j_next = idx_j;
    cur_next   = cur;
    res_next   = res;
    done_next  = 1'b0;
    we         = 1'b0;
    waddr      = '0;
    wdata      = cur;
    raddr      = '0;

    case (state)
      S_IDLE: begin
        if (start) begin
          res_next = '0;
          case (cmd.opcode)
            OP_INSERT: begin
              if (count >= CNT_W'(TABLE_DEPTH)) begin
                res_next.status = STAT_FULL;
              end else begin
                we         = 1'b1;
                waddr      = count[IDX_W-1:0];
                wdata      = '{tag: cmd.name_tag, prio: cmd.priority_req,
                               size: cmd.size_value};
                count_next = count + 1'b1;
              end
              done_next = 1'b1;
            end
            OP_REMOVE: begin
              if (count == '0) begin
                res_next.status = STAT_EMPTY;
                done_next       = 1'b1;
              end else begin
                raddr      = '0;
                idx_j_next = CNT_W'(1);
                state_next = S_REM_HEAD;
              end
            end
            OP_SORT: begin
              if (count < CNT_W'(2)) begin
                done_next = 1'b1;
              end else begin
                raddr      = '0;
                idx_i_next = '0;
                state_next = S_SORT_I;
              end
            end
            default: begin
              done_next = 1'b1;
            end
          endcase
        end
      end

      S_REM_HEAD: begin
        res_next.removed_tag      = rd_entry.tag;
        res_next.removed_priority = rd_entry.prio;
        res_next.removed_size     = rd_entry.size;
        if (idx_j < count) begin
          raddr      = idx_j[IDX_W-1:0];
          state_next = S_REM_SHIFT;
        end else begin
          count_next = count - 1'b1;
          done_next  = 1'b1;
          state_next = S_IDLE;
        end
      end

      // Entry j arrives from the RAM and moves down one slot while j+1 is read.
      S_REM_SHIFT: begin
        we         = 1'b1;
        waddr      = IDX_W'(idx_j - 1'b1);
        wdata      = rd_entry;
        idx_j_next = j_inc;
        if (j_inc < count) begin
          raddr = j_inc[IDX_W-1:0];
        end else begin
          count_next = count - 1'b1;
          done_next  = 1'b1;
          state_next = S_IDLE;
        end
      end

      // cur keeps the least entry seen in the inner pass and is written to slot i at its end.
      S_SORT_I: begin
        cur_next   = rd_entry;
        idx_j_next = i_inc;
        raddr      = i_inc[IDX_W-1:0];
        state_next = S_SORT_J;
      end

      S_SORT_J: begin
        if (entry_greater(cur, rd_entry)) begin
          we       = 1'b1;
          waddr    = idx_j[IDX_W-1:0];
          wdata    = cur;
          cur_next = rd_entry;
        end
        idx_j_next = j_inc;
        if (j_inc < count) begin
          raddr = j_inc[IDX_W-1:0];
        end else begin
          state_next = S_SORT_WB;
        end
      end

      S_SORT_WB: begin
        we         = 1'b1;
        waddr      = idx_i[IDX_W-1:0];
        wdata      = cur;
        idx_i_next = i_inc;
        if (i_inc2 < count) begin
          raddr      = i_inc[IDX_W-1:0];
          state_next = S_SORT_I;
        end else begin
          done_next  = 1'b1;
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase

    if (done_next) begin
      res_next.entry_count = 7'(count_next);
    end
  end

  assign busy   = (state != S_IDLE);
  assign result = res;

endmodule

// File: hw/rtl/ppt_ram.sv
// Simple dual-port RAM with one write port and one registered read port.
module ppt_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 64,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: tb/sv/tb_process_priority_table_unit.sv
// Self-checking testbench for the process priority table unit.
`timescale 1ns / 1ps

module tb_process_priority_table_unit;
  import ppt_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef struct {
    in_item_t  cmd;
    bit        typed;
    out_item_t res;
  } plan_row_t;

  logic      clk   = 1'b0;
  logic      rst   = 1'b1;
  logic      start = 1'b0;
  in_item_t  cmd   = '0;
  logic      busy;
  logic      done;
  out_item_t result;

  // Shadow copy of the table, kept in step with every accepted item.
  entry_t    shadow_tbl [TABLE_DEPTH];
  int        shadow_count = 0;
  out_item_t op_outcomes [$];
  plan_row_t plan [$];

  int idle_pct    = 0;
  int fail_count  = 0;
  int checked     = 0;
  int peak_count  = 0;
  int full_hits   = 0;
  int empty_hits  = 0;
  int op_tally [4] = '{0, 0, 0, 0};

  process_priority_table_unit dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .cmd    (cmd),
    .busy   (busy),
    .done   (done),
    .result (result)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #15_000_000;
    $display("FAIL");
    $finish;
  end

  function automatic in_item_t mk_in(logic [1:0] op, logic [15:0] tag, logic [15:0] prio,
                                     logic [31:0] size);
    in_item_t c;
    c.opcode       = op;
    c.name_tag     = tag;
    c.priority_req = prio;
    c.size_value   = size;
    return c;
  endfunction

  function automatic out_item_t mk_out(logic [1:0] st, logic [15:0] tag, logic [15:0] prio,
                                       logic [31:0] size, logic [6:0] cnt);
    out_item_t r;
    r.status           = st;
    r.removed_tag      = tag;
    r.removed_priority = prio;
    r.removed_size     = size;
    r.entry_count      = cnt;
    return r;
  endfunction

  // Ordering key: priority first, size breaks ties.
  function automatic bit sorts_after(entry_t a, entry_t b);
    if (a.prio != b.prio) begin
      return $signed(a.prio) > $signed(b.prio);
    end
    return a.size > b.size;
  endfunction

  task automatic run_table_op(input in_item_t c, output out_item_t r);
    entry_t hold;
    r = '0;
    case (c.opcode)
      OP_INSERT: begin
        if (shadow_count >= TABLE_DEPTH) begin
          r.status = STAT_FULL;
          full_hits++;
        end else begin
          shadow_tbl[shadow_count] = '{tag: c.name_tag, prio: c.priority_req,
                                       size: c.size_value};
          shadow_count++;
        end
      end
      OP_REMOVE: begin
        if (shadow_count == 0) begin
          r.status = STAT_EMPTY;
          empty_hits++;
        end else begin
          r.removed_tag      = shadow_tbl[0].tag;
          r.removed_priority = shadow_tbl[0].prio;
          r.removed_size     = shadow_tbl[0].size;
          for (int i = 0; i + 1 < shadow_count; i++) shadow_tbl[i] = shadow_tbl[i + 1];
          shadow_count--;
        end
      end
      OP_SORT: begin
        // The exchange order matters: equal keys with different tags end up
        // wherever this exact sequence of swaps leaves them.
        for (int i = 0; i < shadow_count; i++) begin
          for (int j = i; j < shadow_count; j++) begin
            if (sorts_after(shadow_tbl[i], shadow_tbl[j])) begin
              hold          = shadow_tbl[i];
              shadow_tbl[i] = shadow_tbl[j];
              shadow_tbl[j] = hold;
            end
          end
        end
      end
      default: ;
    endcase
    r.entry_count = shadow_count[6:0];
    if (shadow_count > peak_count) peak_count = shadow_count;
  endtask

  task automatic issue(input in_item_t c, input bit typed = 1'b0,
                       input out_item_t typed_res = '0);
    out_item_t r;
    cmd   <= c;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    run_table_op(c, r);
    op_tally[c.opcode]++;
    op_outcomes.push_back(typed ? typed_res : r);
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  endtask

  task automatic settle();
    start <= 1'b0;
    do @(posedge clk); while (op_outcomes.size() != 0);
  endtask

  function automatic logic [1:0] pick_op(int w_ins, int w_rem, int w_sort);
    int r;
    r = $urandom_range(99);
    if (r < w_ins) return OP_INSERT;
    if (r < w_ins + w_rem) return OP_REMOVE;
    if (r < w_ins + w_rem + w_sort) return OP_SORT;
    return OP_UNUSED;
  endfunction

  // Priorities and sizes are often drawn from a few values so that sorting
  // meets ties on priority and on the whole key.
  function automatic in_item_t rand_cmd(logic [1:0] op);
    logic [15:0] prio;
    logic [31:0] size;
    case ($urandom_range(9))
      0:       prio = 16'h8000;
      1:       prio = 16'h7fff;
      2, 3, 4: prio = 16'($urandom_range(4) - 2);
      default: prio = 16'($urandom);
    endcase
    case ($urandom_range(9))
      0:       size = 32'h0000_0000;
      1:       size = 32'hffff_ffff;
      2, 3, 4: size = 32'($urandom_range(1, 3)) << 7;
      default: size = $urandom;
    endcase
    return mk_in(op, 16'($urandom), prio, size);
  endfunction

  task automatic run_mix(int n, int w_ins, int w_rem, int w_sort);
    repeat (n) issue(rand_cmd(pick_op(w_ins, w_rem, w_sort)));
  endtask

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin : watch_results
    out_item_t want;
    if (!rst && done) begin
      if (op_outcomes.size() == 0) begin
        $display("%0t: unexpected result %h", $time, result);
        fail_count++;
      end else begin
        want = op_outcomes.pop_front();
        checked++;
        compare_field("status", 32'(want.status), 32'(result.status));
        compare_field("removed_tag", 32'(want.removed_tag), 32'(result.removed_tag));
        compare_field("removed_priority", 32'(16'(want.removed_priority)),
                      32'(16'(result.removed_priority)));
        compare_field("removed_size", want.removed_size, result.removed_size);
        compare_field("entry_count", 32'(want.entry_count), 32'(result.entry_count));
      end
    end
  end

  initial begin
    plan.push_back('{mk_in(OP_REMOVE, 16'ha5a5, 16'h1234, 32'hdead_beef), 1'b1,
                     mk_out(STAT_EMPTY, 16'h0, 16'h0, 32'h0, 7'd0)});
    plan.push_back('{mk_in(OP_SORT, 16'hffff, 16'h7fff, 32'hffff_ffff), 1'b1,
                     mk_out(STAT_OK, 16'h0, 16'h0, 32'h0, 7'd0)});
    plan.push_back('{mk_in(OP_UNUSED, 16'h5a5a, 16'hffff, 32'h1234_5678), 1'b1,
                     mk_out(STAT_OK, 16'h0, 16'h0, 32'h0, 7'd0)});
    plan.push_back('{mk_in(OP_INSERT, 16'hffff, 16'h7fff, 32'hffff_ffff), 1'b1,
                     mk_out(STAT_OK, 16'h0, 16'h0, 32'h0, 7'd1)});
    plan.push_back('{mk_in(OP_SORT, 16'h0, 16'h0, 32'h0), 1'b1,
                     mk_out(STAT_OK, 16'h0, 16'h0, 32'h0, 7'd1)});
    plan.push_back('{mk_in(OP_REMOVE, 16'h0, 16'h0, 32'h0), 1'b1,
                     mk_out(STAT_OK, 16'hffff, 16'h7fff, 32'hffff_ffff, 7'd0)});
    plan.push_back('{mk_in(OP_INSERT, 16'h0000, 16'h8000, 32'h0), 1'b1,
                     mk_out(STAT_OK, 16'h0, 16'h0, 32'h0, 7'd1)});
    plan.push_back('{mk_in(OP_INSERT, 16'h1234, 16'h7fff, 32'h0), 1'b1,
                     mk_out(STAT_OK, 16'h0, 16'h0, 32'h0, 7'd2)});
    plan.push_back('{mk_in(OP_INSERT, 16'h0005, 16'h0000, 32'h100), 1'b1,
                     mk_out(STAT_OK, 16'h0, 16'h0, 32'h0, 7'd3)});
    plan.push_back('{mk_in(OP_INSERT, 16'h0006, 16'h0000, 32'h80), 1'b1,
                     mk_out(STAT_OK, 16'h0, 16'h0, 32'h0, 7'd4)});
    plan.push_back('{mk_in(OP_INSERT, 16'h0007, 16'h0000, 32'h80), 1'b1,
                     mk_out(STAT_OK, 16'h0, 16'h0, 32'h0, 7'd5)});
    plan.push_back('{mk_in(OP_INSERT, 16'h0008, 16'hffff, 32'hffff_ffff), 1'b1,
                     mk_out(STAT_OK, 16'h0, 16'h0, 32'h0, 7'd6)});
    plan.push_back('{mk_in(OP_UNUSED, 16'hffff, 16'h7fff, 32'hffff_ffff), 1'b1,
                     mk_out(STAT_OK, 16'h0, 16'h0, 32'h0, 7'd6)});
    plan.push_back('{mk_in(OP_SORT, 16'h0, 16'h0, 32'h0), 1'b0, '0});
    for (int k = 0; k < 6; k++) begin
      plan.push_back('{mk_in(OP_REMOVE, k[0] ? 16'hffff : 16'h0, k[0] ? 16'h8000 : 16'h7fff,
                             k[0] ? 32'hffff_ffff : 32'h0), 1'b0, '0});
    end
    plan.push_back('{mk_in(OP_REMOVE, 16'h0, 16'h0, 32'h0), 1'b1,
                     mk_out(STAT_EMPTY, 16'h0, 16'h0, 32'h0, 7'd0)});
    plan.push_back('{mk_in(OP_INSERT, 16'h00aa, 16'h0003, 32'h100), 1'b0, '0});
    plan.push_back('{mk_in(OP_INSERT, 16'h00bb, 16'h0003, 32'h100), 1'b0, '0});
    plan.push_back('{mk_in(OP_SORT, 16'h0, 16'h0, 32'h0), 1'b0, '0});
    plan.push_back('{mk_in(OP_REMOVE, 16'h0, 16'h0, 32'h0), 1'b0, '0});

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[k]) issue(plan[k].cmd, plan[k].typed, plan[k].res);
    settle();

    // Fill the table to the brim, knock on it while full, then sort it whole.
    idle_pct = 0;
    run_mix(55, 90, 4, 3);
    while (shadow_count < TABLE_DEPTH) issue(rand_cmd(OP_INSERT));
    repeat (2) issue(rand_cmd(OP_INSERT));
    issue(rand_cmd(OP_SORT));
    settle();

    idle_pct = 51;
    run_mix(20, 35, 40, 20);
    settle();

    // Drain to empty and remove past the bottom.
    idle_pct = 21;
    run_mix(15, 10, 80, 7);
    while (shadow_count > 0) issue(rand_cmd(OP_REMOVE));
    repeat (2) issue(rand_cmd(OP_REMOVE));
    settle();

    idle_pct = 0;
    run_mix(15, 45, 30, 15);
    settle();
    repeat (20) @(posedge clk);

    $display("Ran %0d inserts, %0d removes, %0d sorts and %0d unused opcodes; %0d results checked.",
             op_tally[OP_INSERT], op_tally[OP_REMOVE], op_tally[OP_SORT], op_tally[OP_UNUSED],
             checked);
    $display("Table peaked at %0d entries, with %0d full rejects and %0d empty removes.",
             peak_count, full_hits, empty_hits);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// File: sim.f
hw/rtl/ppt_pkg.sv
hw/rtl/ppt_ram.sv
hw/rtl/process_priority_table_unit.sv
tb/sv/tb_process_priority_table_unit.sv
